@@ rtl/core/pwsfd_pkg.sv @@
// ----------------------------------------------------------------------------
// pwsfd_pkg
// Shared types and constants for the pulse width sensor frame decoder.
// ----------------------------------------------------------------------------
package pwsfd_pkg;

    localparam int unsigned DUR_W        = 10;
    localparam int unsigned TRANS_W      = 7;
    localparam int unsigned BIT_CNT_W    = 6;
    localparam int unsigned FRAME_BYTES  = 5;
    localparam int unsigned FRAME_BITS   = 40;
    localparam int unsigned DATA_W       = 16;
    localparam int unsigned CFG_IDX_W    = 3;

    localparam int unsigned MAX_TRANSITIONS_DEF = 100;
    localparam int unsigned MIN_TRANSITIONS     = 40;
    localparam int unsigned HUM_MAX_TENTHS      = 1000;

    localparam logic [DUR_W-1:0] MIN_PULSE_RST = 10'd20;
    localparam logic [DUR_W-1:0] MAX_PULSE_RST = 10'd80;
    localparam logic [DUR_W-1:0] ONE_THR_RST   = 10'd40;

    typedef logic [7:0] t_byte;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_PULSE = 3'd1,
        ST_CHECKSUM  = 3'd2,
        ST_SHORT     = 3'd3,
        ST_HUM_RANGE = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENSOR_KIND = 3'd0,
        CFG_MIN_PULSE   = 3'd1,
        CFG_MAX_PULSE   = 3'd2,
        CFG_ONE_THR     = 3'd3
    } t_cfg_idx;

    localparam logic KIND_TENTHS = 1'b0;

endpackage

@@ rtl/core/pulse_width_sensor_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// pulse_width_sensor_frame_decoder
// Decodes single-wire sensor frames from line transition timings.
// ----------------------------------------------------------------------------
// Takes one item per cycle: each item is one line transition (microseconds
// since the previous one) or an end-of-frame marker. An accepted item is
// registered, then judged and folded into the frame state;
// when it closes a frame (end-of-frame or the MAX_TRANSITIONS-th transition)
// the status, humidity and temperature are registered in the output
// register, which offers the result. The output register lets new items flow
// in while a result waits under stall; the input only stalls when a closing
// item meets a full, stalled output.
// Configuration writes are always ready.
module pulse_width_sensor_frame_decoder #(
    parameter int unsigned MAX_TRANSITIONS = pwsfd_pkg::MAX_TRANSITIONS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // transition items
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [pwsfd_pkg::DUR_W-1:0]           i_duration_us,
    input  logic                                  i_end_of_frame,
    // results
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [2:0]                            o_status,
    output logic [pwsfd_pkg::DATA_W-1:0]          o_humidity_tenths,
    output logic signed [pwsfd_pkg::DATA_W-1:0]   o_temperature_tenths,
    // configuration
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [pwsfd_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [pwsfd_pkg::DUR_W-1:0]           i_cfg_data
);

    localparam int unsigned TW = pwsfd_pkg::TRANS_W;
    localparam int unsigned DW = pwsfd_pkg::DUR_W;
    localparam int unsigned BW = pwsfd_pkg::BIT_CNT_W;
    localparam int unsigned NB = pwsfd_pkg::FRAME_BYTES;
    localparam logic [TW-1:0] MAX_T = TW'(MAX_TRANSITIONS);

    // configuration
    logic          r_sensor_kind;
    logic [DW-1:0] r_min_pulse;
    logic [DW-1:0] r_max_pulse;
    logic [DW-1:0] r_one_thr;

    // input register
    logic          r_in_valid;
    logic [DW-1:0] r_dur;
    logic          r_eof;

    // frame state
    logic [TW-1:0]      r_trans_cnt, n_trans_cnt;
    logic [BW-1:0]      r_bit_cnt,   n_bit_cnt;
    pwsfd_pkg::t_byte   r_frame [NB];
    pwsfd_pkg::t_byte   n_frame [NB];
    logic               r_pulse_err, n_pulse_err;

    // output register
    logic                      r_out_valid;
    pwsfd_pkg::t_status        r_status, n_status;
    logic [pwsfd_pkg::DATA_W-1:0] r_hum, n_hum;
    logic [pwsfd_pkg::DATA_W-1:0] r_temp, n_temp;

    logic          judge, bad, push, bit_val, close, can_write, advance;
    logic [2:0]    byte_sel;
    logic [7:0]    sum;
    logic [14:0]   mag;
    logic [pwsfd_pkg::DATA_W-1:0] hum_raw, temp_raw;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_kind <= pwsfd_pkg::KIND_TENTHS;
            r_min_pulse   <= pwsfd_pkg::MIN_PULSE_RST;
            r_max_pulse   <= pwsfd_pkg::MAX_PULSE_RST;
            r_one_thr     <= pwsfd_pkg::ONE_THR_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                pwsfd_pkg::CFG_SENSOR_KIND: r_sensor_kind <= i_cfg_data[0];
                pwsfd_pkg::CFG_MIN_PULSE:   r_min_pulse   <= i_cfg_data;
                pwsfd_pkg::CFG_MAX_PULSE:   r_max_pulse   <= i_cfg_data;
                pwsfd_pkg::CFG_ONE_THR:     r_one_thr     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // item handling
    assign judge    = !r_eof && (r_trans_cnt > TW'(1)) && !r_trans_cnt[0] && !r_pulse_err;
    assign bad      = (r_dur < r_min_pulse) || (r_dur > r_max_pulse);
    assign push     = judge && !bad && (r_bit_cnt < BW'(pwsfd_pkg::FRAME_BITS));
    assign bit_val  = r_dur > r_one_thr;
    assign byte_sel = r_bit_cnt[5:3];

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            n_frame[i] = (push && byte_sel == 3'(i)) ? {r_frame[i][6:0], bit_val}
                                                     : r_frame[i];
        end
    end

    assign n_bit_cnt   = push ? r_bit_cnt + BW'(1) : r_bit_cnt;
    assign n_pulse_err = r_pulse_err || (judge && bad);
    assign n_trans_cnt = r_eof ? r_trans_cnt : r_trans_cnt + TW'(1);
    assign close       = r_eof || (n_trans_cnt == MAX_T);

    // frame evaluation
    assign sum = n_frame[0] + n_frame[1] + n_frame[2] + n_frame[3];

    always_comb begin
        if (r_sensor_kind == pwsfd_pkg::KIND_TENTHS) begin
            hum_raw = {n_frame[0], n_frame[1]};
            mag     = {n_frame[2][6:0], n_frame[3]};
        end else begin
            hum_raw = 16'(12'(n_frame[0]) * 12'd10);
            mag     = 15'(11'(n_frame[2][6:0]) * 11'd10);
        end
        temp_raw = n_frame[2][7] ? 16'(16'd0 - 16'(mag)) : 16'(mag);

        if (n_pulse_err) begin
            n_status = pwsfd_pkg::ST_BAD_PULSE;
        end else if (sum != n_frame[4] || sum == 8'd0) begin
            n_status = pwsfd_pkg::ST_CHECKSUM;
        end else if (n_trans_cnt <= TW'(pwsfd_pkg::MIN_TRANSITIONS)) begin
            n_status = pwsfd_pkg::ST_SHORT;
        end else if (hum_raw > 16'(pwsfd_pkg::HUM_MAX_TENTHS)) begin
            n_status = pwsfd_pkg::ST_HUM_RANGE;
        end else begin
            n_status = pwsfd_pkg::ST_OK;
        end
        n_hum  = (n_status == pwsfd_pkg::ST_OK) ? hum_raw  : '0;
        n_temp = (n_status == pwsfd_pkg::ST_OK) ? temp_raw : '0;
    end

    // flow control
    assign can_write  = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (can_write || !close);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_dur <= i_duration_us;
            r_eof <= i_end_of_frame;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_cnt <= '0;
            r_bit_cnt   <= '0;
            r_pulse_err <= 1'b0;
            for (int i = 0; i < NB; i++) begin
                r_frame[i] <= '0;
            end
        end else if (advance) begin
            if (close) begin
                r_trans_cnt <= '0;
                r_bit_cnt   <= '0;
                r_pulse_err <= 1'b0;
                for (int i = 0; i < NB; i++) begin
                    r_frame[i] <= '0;
                end
            end else begin
                r_trans_cnt <= n_trans_cnt;
                r_bit_cnt   <= n_bit_cnt;
                r_pulse_err <= n_pulse_err;
                for (int i = 0; i < NB; i++) begin
                    r_frame[i] <= n_frame[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && close) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && close) begin
            r_status <= n_status;
            r_hum    <= n_hum;
            r_temp   <= n_temp;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_status             = r_status;
    assign o_humidity_tenths    = r_hum;
    assign o_temperature_tenths = r_temp;

`ifndef SYNTHESIS
    a_trans_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_trans_cnt < MAX_T)
        else $error("transition count reached frame limit without close");

    a_bit_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_cnt <= BW'(pwsfd_pkg::FRAME_BITS))
        else $error("bit count beyond frame size");

    a_err_needs_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pulse_err |-> r_trans_cnt > TW'(2))
        else $error("pulse error set before any judged pulse");

    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pwsfd_pkg::ST_OK)
            |-> (o_humidity_tenths == '0 && o_temperature_tenths == '0))
        else $error("failed frame carries nonzero data");
`endif

endmodule
